@@ hw/rtl/pbsq_pkg.sv @@
// ----------------------------------------------------------------------------
// pbsq_pkg: shared types and constants
// Widths, bucket statistics word and divider request/response words.
// ----------------------------------------------------------------------------
package pbsq_pkg;

  localparam int PIX_AW      = 16;
  localparam int MAX_PIXELS  = 1 << PIX_AW;
  localparam int CNT_W       = PIX_AW + 1;
  localparam int MAX_COLOURS = 64;
  localparam int BKT_W       = 6;
  localparam int TOT_W       = 7;
  localparam int NCH         = 4;
  localparam int CH_W        = 2;
  localparam int MEAN_W      = 16;
  localparam int SPR_W       = 32;
  localparam int SUM_W       = 24;
  localparam int DVD_W       = 32;
  localparam int PC_W        = 7;
  localparam logic [PC_W-1:0] PC_RESET = 7'd16;

  typedef struct packed {
    logic [NCH-1:0][MEAN_W-1:0] mean;
    logic [SPR_W-1:0]           spread;
    logic [CH_W-1:0]            wid;
  } stat_t;

  localparam int ST_W = $bits(stat_t);

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [7:0] round_mean(input logic [MEAN_W-1:0] m);
    logic [MEAN_W:0] s;
    s = {1'b0, m} + 17'd128;
    round_mean = s[MEAN_W] ? 8'hFF : s[MEAN_W-1:8];
  endfunction

endpackage

@@ hw/rtl/palette_bucket_split_quantizer.sv @@
// ----------------------------------------------------------------------------
// palette_bucket_split_quantizer: mean-split palette quantizer
// Stores pixels, splits buckets at or one below the rounded mean, emits palette words.
//
//   channel  dir  handshake           word
//   in_      in   in_valid/in_stall   chan0..3, last_pixel
//   out_     out  out_valid/out_stall entry_index, chan0..3, last_entry
//   cfg_     in   cfg_valid/cfg_ready palette_count
//
// Load: one pixel word per cycle while in_stall is low. After last_pixel the
// sequencer makes six passes over the pixel RAM per bucket split for sums,
// spread, split counts and reassignment, and uses the shared divider once per
// channel for the mean of each non-empty bucket.
// in_stall is high from last_pixel until the final palette word is taken.
// Reset (rst_n low, synchronous) empties the image and sets 16 colours.
// ----------------------------------------------------------------------------
module palette_bucket_split_quantizer import pbsq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_chan0,
  input  logic [7:0]      in_chan1,
  input  logic [7:0]      in_chan2,
  input  logic [7:0]      in_chan3,
  input  logic            in_last_pixel,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [5:0]      out_entry_index,
  output logic [7:0]      out_chan0,
  output logic [7:0]      out_chan1,
  output logic [7:0]      out_chan2,
  output logic [7:0]      out_chan3,
  output logic            out_last_entry,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [PC_W-1:0] cfg_data
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_SUM  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_DIVW = 4'd3;
  localparam logic [3:0] S_SPR  = 4'd4;
  localparam logic [3:0] S_WID  = 4'd5;
  localparam logic [3:0] S_WR   = 4'd6;
  localparam logic [3:0] S_SEL  = 4'd7;
  localparam logic [3:0] S_SPL0 = 4'd8;
  localparam logic [3:0] S_SPL1 = 4'd9;
  localparam logic [3:0] S_CNT  = 4'd10;
  localparam logic [3:0] S_CHS  = 4'd11;
  localparam logic [3:0] S_MOV  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;
  localparam logic [3:0] S_OUTL = 4'd14;
  localparam logic [3:0] S_OUTW = 4'd15;

  localparam logic [1:0] R_INIT = 2'd0;
  localparam logic [1:0] R_LOW  = 2'd1;
  localparam logic [1:0] R_HIGH = 2'd2;

  logic [3:0]                 state_r, state_nxt;
  logic [PC_W-1:0]            pc_r, pc_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           idx_r, idx_nxt;
  logic                       rv_r, rv_nxt;
  logic [PIX_AW-1:0]          ra_r, ra_nxt;
  logic [BKT_W-1:0]           rb_r, rb_nxt;
  logic [1:0]                 rph_r, rph_nxt;
  logic [TOT_W-1:0]           total_r, total_nxt;
  logic [CNT_W-1:0]           n_r, n_nxt;
  logic [NCH-1:0][SUM_W-1:0]  sum_r, sum_nxt;
  logic [NCH-1:0][MEAN_W-1:0] mean_r, mean_nxt;
  logic [NCH-1:0][SPR_W-1:0]  spr_r, spr_nxt;
  logic [CH_W-1:0]            ch_r, ch_nxt;
  logic [CH_W-1:0]            wid_r, wid_nxt;
  logic [TOT_W-1:0]           sidx_r, sidx_nxt;
  logic                       srv_r, srv_nxt;
  logic [BKT_W-1:0]           best_r, best_nxt;
  logic [SPR_W-1:0]           bests_r, bests_nxt;
  logic [CH_W-1:0]            w_r, w_nxt;
  logic [7:0]                 ta_r, ta_nxt;
  logic [7:0]                 tb_r, tb_nxt;
  logic [7:0]                 t_r, t_nxt;
  logic [CNT_W-1:0]           nn_r, nn_nxt;
  logic [CNT_W-1:0]           la_r, la_nxt;
  logic [CNT_W-1:0]           lb_r, lb_nxt;
  logic [BKT_W-1:0]           ob_r, ob_nxt;
  logic                       ov_r, ov_nxt;
  logic [NCH-1:0][7:0]        oc_r, oc_nxt;
  logic                       ol_r, ol_nxt;

  logic [PC_W-1:0]            target_w;
  logic                       in_acc;
  logic                       pix_we;
  logic [31:0]                pix_rd;
  logic [NCH-1:0][7:0]        chv;
  logic                       bkt_we;
  logic [PIX_AW-1:0]          bkt_wa;
  logic [BKT_W-1:0]           bkt_wd;
  logic [BKT_W-1:0]           bkt_rd;
  logic                       st_we;
  stat_t                      st_wd;
  stat_t                      st_rd;
  logic [ST_W-1:0]            st_rd_raw;
  logic [BKT_W-1:0]           st_ra;
  div_req_t                   dreq;
  div_rsp_t                   drsp;
  logic                       scan_go;
  logic                       scan_done;
  logic                       mine;
  logic [7:0]                 vw;
  logic [7:0]                 a_w;
  logic [CNT_W-1:0]           ha, hb, da, db;
  logic [MEAN_W-1:0]          vx, dev;

  assign target_w  = (pc_r == '0) ? PC_W'(1) :
                     (pc_r > PC_W'(MAX_COLOURS)) ? PC_W'(MAX_COLOURS) : pc_r;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = state_r != S_LOAD;
  assign cfg_ready = 1'b1;
  assign pix_we    = in_acc && (cnt_r < CNT_W'(MAX_PIXELS));
  assign chv       = pix_rd;
  assign st_rd     = stat_t'(st_rd_raw);
  assign scan_go   = idx_r < cnt_r;
  assign scan_done = (idx_r == cnt_r) && !rv_r;
  assign vw        = chv[w_r];

  pbsq_ram #(.W(32), .D(MAX_PIXELS)) u_pix (
    .clk   (clk),
    .we    (pix_we),
    .waddr (cnt_r[PIX_AW-1:0]),
    .wdata ({in_chan3, in_chan2, in_chan1, in_chan0}),
    .raddr (idx_r[PIX_AW-1:0]),
    .rdata (pix_rd)
  );

  pbsq_ram #(.W(BKT_W), .D(MAX_PIXELS)) u_bkt (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_wa),
    .wdata (bkt_wd),
    .raddr (idx_r[PIX_AW-1:0]),
    .rdata (bkt_rd)
  );

  pbsq_ram #(.W(ST_W), .D(MAX_COLOURS)) u_stat (
    .clk   (clk),
    .we    (st_we),
    .waddr (rb_r),
    .wdata (st_wd),
    .raddr (st_ra),
    .rdata (st_rd_raw)
  );

  pbsq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    rv_nxt    = 1'b0;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    rph_nxt   = rph_r;
    total_nxt = total_r;
    n_nxt     = n_r;
    sum_nxt   = sum_r;
    mean_nxt  = mean_r;
    spr_nxt   = spr_r;
    ch_nxt    = ch_r;
    wid_nxt   = wid_r;
    sidx_nxt  = sidx_r;
    srv_nxt   = 1'b0;
    best_nxt  = best_r;
    bests_nxt = bests_r;
    w_nxt     = w_r;
    ta_nxt    = ta_r;
    tb_nxt    = tb_r;
    t_nxt     = t_r;
    nn_nxt    = nn_r;
    la_nxt    = la_r;
    lb_nxt    = lb_r;
    ob_nxt    = ob_r;
    ov_nxt    = ov_r;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    bkt_we    = 1'b0;
    bkt_wa    = ra_r;
    bkt_wd    = total_r[BKT_W-1:0];
    st_we     = 1'b0;
    st_wd     = '{mean: mean_r, spread: spr_r[wid_r], wid: wid_r};
    st_ra     = best_r;
    dreq      = '{start: 1'b0,
                  dividend: {sum_r[ch_r], 8'h00} + DVD_W'(n_r >> 1),
                  divisor: n_r};
    mine      = rv_r && (bkt_rd == rb_r);
    a_w       = round_mean(st_rd.mean[st_rd.wid]);
    ha        = nn_r - la_r;
    hb        = nn_r - lb_r;
    da        = (la_r >= ha) ? la_r - ha : ha - la_r;
    db        = (lb_r >= hb) ? lb_r - hb : hb - lb_r;
    vx        = '0;
    dev       = '0;

    if (cfg_valid) begin
      pc_nxt = cfg_data;
    end

    if (scan_go) begin
      idx_nxt = idx_r + 1'b1;
      rv_nxt  = 1'b1;
      ra_nxt  = idx_r[PIX_AW-1:0];
    end

    unique case (state_r)
      S_LOAD: begin
        rv_nxt = 1'b0;
        bkt_we = pix_we;
        bkt_wa = cnt_r[PIX_AW-1:0];
        bkt_wd = '0;
        if (pix_we) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (in_acc && in_last_pixel) begin
          rb_nxt    = '0;
          rph_nxt   = R_INIT;
          idx_nxt   = '0;
          n_nxt     = '0;
          sum_nxt   = '0;
          spr_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (mine) begin
          n_nxt = n_r + 1'b1;
          for (int c = 0; c < NCH; c++) begin
            sum_nxt[c] = sum_r[c] + SUM_W'(chv[c]);
          end
        end
        if (scan_done) begin
          ch_nxt    = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (n_r == '0) begin
          mean_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = S_SPR;
        end else begin
          dreq.start = 1'b1;
          state_nxt  = S_DIVW;
        end
      end
      S_DIVW: begin
        if (drsp.done) begin
          mean_nxt[ch_r] = drsp.quot;
          if (ch_r == CH_W'(NCH - 1)) begin
            idx_nxt   = '0;
            state_nxt = S_SPR;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_SPR: begin
        if (mine) begin
          for (int c = 0; c < NCH; c++) begin
            vx = {chv[c], 8'h00};
            dev = (vx >= mean_r[c]) ? vx - mean_r[c] : mean_r[c] - vx;
            spr_nxt[c] = spr_r[c] + SPR_W'(dev);
          end
        end
        if (scan_done) begin
          ch_nxt    = CH_W'(1);
          wid_nxt   = '0;
          state_nxt = S_WID;
        end
      end
      S_WID: begin
        if (spr_r[ch_r] > spr_r[wid_r]) begin
          wid_nxt = ch_r;
        end
        if (ch_r == CH_W'(NCH - 1)) begin
          state_nxt = S_WR;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end
      S_WR: begin
        st_we = 1'b1;
        sidx_nxt  = '0;
        best_nxt  = '0;
        bests_nxt = '0;
        unique case (rph_r)
          R_INIT: begin
            total_nxt = TOT_W'(1);
            state_nxt = S_SEL;
          end
          R_LOW: begin
            rb_nxt    = total_r[BKT_W-1:0];
            rph_nxt   = R_HIGH;
            idx_nxt   = '0;
            n_nxt     = '0;
            sum_nxt   = '0;
            spr_nxt   = '0;
            state_nxt = S_SUM;
          end
          default: begin
            total_nxt = total_r + 1'b1;
            state_nxt = S_SEL;
          end
        endcase
      end
      S_SEL: begin
        st_ra = sidx_r[BKT_W-1:0];
        if (total_r >= target_w) begin
          ob_nxt    = '0;
          state_nxt = S_OUT;
        end else begin
          if (sidx_r < total_r) begin
            sidx_nxt = sidx_r + 1'b1;
            srv_nxt  = 1'b1;
          end
          if (srv_r && (st_rd.spread > bests_r)) begin
            bests_nxt = st_rd.spread;
            best_nxt  = BKT_W'(sidx_r - 1'b1);
          end
          if ((sidx_r == total_r) && !srv_r) begin
            state_nxt = S_SPL0;
          end
        end
      end
      S_SPL0: begin
        state_nxt = S_SPL1;
      end
      S_SPL1: begin
        w_nxt     = st_rd.wid;
        ta_nxt    = a_w;
        tb_nxt    = (a_w == 8'h00) ? 8'h00 : a_w - 1'b1;
        rb_nxt    = best_r;
        idx_nxt   = '0;
        nn_nxt    = '0;
        la_nxt    = '0;
        lb_nxt    = '0;
        state_nxt = S_CNT;
      end
      S_CNT: begin
        if (mine) begin
          nn_nxt = nn_r + 1'b1;
          if (vw <= ta_r) la_nxt = la_r + 1'b1;
          if (vw <= tb_r) lb_nxt = lb_r + 1'b1;
        end
        if (scan_done) begin
          state_nxt = S_CHS;
        end
      end
      S_CHS: begin
        t_nxt     = (da < db) ? ta_r : tb_r;
        idx_nxt   = '0;
        state_nxt = S_MOV;
      end
      S_MOV: begin
        bkt_we = mine && (vw > t_r);
        if (scan_done) begin
          rph_nxt   = R_LOW;
          idx_nxt   = '0;
          n_nxt     = '0;
          sum_nxt   = '0;
          spr_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_OUT: begin
        st_ra     = ob_r;
        state_nxt = S_OUTL;
      end
      S_OUTL: begin
        for (int c = 0; c < NCH; c++) begin
          oc_nxt[c] = round_mean(st_rd.mean[c]);
        end
        ol_nxt    = (PC_W'(ob_r) + 1'b1) == target_w;
        ov_nxt    = 1'b1;
        state_nxt = S_OUTW;
      end
      S_OUTW: begin
        if (ov_r && !out_stall) begin
          ov_nxt = 1'b0;
          if (ol_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            ob_nxt    = ob_r + 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      pc_r    <= PC_RESET;
      cnt_r   <= '0;
      total_r <= '0;
      rv_r    <= 1'b0;
      srv_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      rv_r    <= rv_nxt;
      srv_r   <= srv_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r   <= idx_nxt;
    ra_r    <= ra_nxt;
    rb_r    <= rb_nxt;
    rph_r   <= rph_nxt;
    n_r     <= n_nxt;
    sum_r   <= sum_nxt;
    mean_r  <= mean_nxt;
    spr_r   <= spr_nxt;
    ch_r    <= ch_nxt;
    wid_r   <= wid_nxt;
    sidx_r  <= sidx_nxt;
    best_r  <= best_nxt;
    bests_r <= bests_nxt;
    w_r     <= w_nxt;
    ta_r    <= ta_nxt;
    tb_r    <= tb_nxt;
    t_r     <= t_nxt;
    nn_r    <= nn_nxt;
    la_r    <= la_nxt;
    lb_r    <= lb_nxt;
    ob_r    <= ob_nxt;
    oc_r    <= oc_nxt;
    ol_r    <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_entry_index = ob_r;
  assign out_chan0       = oc_r[0];
  assign out_chan1       = oc_r[1];
  assign out_chan2       = oc_r[2];
  assign out_chan3       = oc_r[3];
  assign out_last_entry  = ol_r;

  a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_OUTW))
    else $error("palette word shown outside output wait");

  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("pixel accepted while palette word pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PIXELS))
    else $error("pixel count past store depth");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(MAX_COLOURS))
    else $error("bucket count past palette depth");

endmodule

@@ hw/rtl/pbsq_ram.sv @@
// ----------------------------------------------------------------------------
// pbsq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pbsq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/pbsq_div.sv @@
// ----------------------------------------------------------------------------
// pbsq_div: iterative restoring divider
// One quotient bit per cycle; quotient known to fit MEAN_W bits.
// ----------------------------------------------------------------------------
module pbsq_div import pbsq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(MEAN_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [MEAN_W-1:0] low_r, low_nxt;
  logic [MEAN_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, low_r[MEAN_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = {1'b0, req.dividend[DVD_W-1:MEAN_W]};
      low_nxt  = req.dividend[MEAN_W-1:0];
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
      quo_nxt  = {quo_r[MEAN_W-2:0], ge};
      low_nxt  = {low_r[MEAN_W-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(MEAN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

@@ sim/palette_bucket_split_quantizer_test.sv @@
// ----------------------------------------------------------------------------
// palette_bucket_split_quantizer_test: palette quantizer testbench
// Streams small images of random and clustered pixels and predicts each
// palette in a behavioral mean-split model; palette words are compared in
// order against that prediction. palette_count is changed between images.
// ----------------------------------------------------------------------------
module palette_bucket_split_quantizer_test;
  import pbsq_pkg::*;

  typedef struct packed {
    logic [5:0] idx;
    logic [7:0] c0, c1, c2, c3;
    logic       last;
  } entry_t;

  class palette_board;
    logic [31:0]  pix [$];
    int unsigned  grp [$];
    logic [7:0]   lo [MAX_COLOURS][NCH];
    logic [7:0]   hi [MAX_COLOURS][NCH];
    int unsigned  mean [MAX_COLOURS][NCH];
    longint unsigned spr [MAX_COLOURS][NCH];
    int unsigned  colours = 16;
    entry_t       pending [$];
    int           errors = 0;

    function int unsigned chv(logic [31:0] p, int c);
      return (p >> (8 * c)) & 8'hFF;
    endfunction

    function bit fits(logic [31:0] p, logic [7:0] l [NCH], logic [7:0] h [NCH]);
      for (int c = 0; c < NCH; c++)
        if (chv(p, c) < l[c] || chv(p, c) > h[c]) return 0;
      return 1;
    endfunction

    function int unsigned rnd(int unsigned m);
      int unsigned r;
      r = (m + 128) >> 8;
      return r > 255 ? 255 : r;
    endfunction

    function void restat(int unsigned b);
      longint unsigned n, s [NCH];
      longint unsigned v, m;
      n = 0;
      for (int c = 0; c < NCH; c++) s[c] = 0;
      foreach (pix[i]) if (grp[i] == b) begin
        n++;
        for (int c = 0; c < NCH; c++) s[c] += chv(pix[i], c);
      end
      for (int c = 0; c < NCH; c++) begin
        mean[b][c] = (n != 0) ? 32'((s[c] * 256 + n / 2) / n) : 0;
        spr[b][c] = 0;
      end
      foreach (pix[i]) if (grp[i] == b)
        for (int c = 0; c < NCH; c++) begin
          v = chv(pix[i], c) * 256;
          m = mean[b][c];
          spr[b][c] += (v >= m) ? v - m : m - v;
        end
    endfunction

    function int wide(int unsigned b);
      int w;
      w = 0;
      for (int c = 1; c < NCH; c++) if (spr[b][c] > spr[b][w]) w = c;
      return w;
    endfunction

    function void divide(int unsigned b, int unsigned nb);
      logic [7:0] la [NCH], lb [NCH], kh [NCH];
      int w;
      int unsigned a, nal, nah, nbl, nbh, da, db;
      bit pick_a;
      w = wide(b);
      a = rnd(mean[b][w]);
      la = hi[b]; lb = hi[b];
      la[w] = 8'(a);
      lb[w] = 8'((a > 0) ? a - 1 : 0);
      nal = 0; nah = 0; nbl = 0; nbh = 0;
      foreach (pix[i]) if (grp[i] == b) begin
        if (fits(pix[i], lo[b], la)) nal++; else nah++;
        if (fits(pix[i], lo[b], lb)) nbl++; else nbh++;
      end
      da = nal > nah ? nal - nah : nah - nal;
      db = nbl > nbh ? nbl - nbh : nbh - nbl;
      pick_a = da < db;
      if (pick_a) kh = la; else kh = lb;
      foreach (pix[i])
        if (grp[i] == b && !fits(pix[i], lo[b], kh)) grp[i] = nb;
      lo[nb] = lo[b];
      hi[nb] = hi[b];
      lo[nb][w] = 8'(pick_a ? ((a < 255) ? a + 1 : 255) : a);
      hi[b] = kh;
      restat(b);
      restat(nb);
    endfunction

    function void note_pixel(logic [7:0] c0, c1, c2, c3, logic last);
      int unsigned tgt, best;
      longint unsigned bs;
      entry_t e;
      if (pix.size() < MAX_PIXELS) begin
        pix.insert(pix.size(), {c3, c2, c1, c0});
        grp.insert(grp.size(), 0);
      end
      if (!last) return;
      tgt = colours < 1 ? 1 : (colours > MAX_COLOURS ? MAX_COLOURS : colours);
      for (int c = 0; c < NCH; c++) begin
        lo[0][c] = 0;
        hi[0][c] = 255;
      end
      foreach (grp[i]) grp[i] = 0;
      restat(0);
      for (int t = 1; t < tgt; t++) begin
        best = 0;
        bs = spr[0][wide(0)];
        for (int b = 1; b < t; b++)
          if (spr[b][wide(b)] > bs) begin
            bs = spr[b][wide(b)];
            best = b;
          end
        divide(best, t);
      end
      for (int b = 0; b < tgt; b++) begin
        e.idx = 6'(b);
        e.c0 = 8'(rnd(mean[b][0]));
        e.c1 = 8'(rnd(mean[b][1]));
        e.c2 = 8'(rnd(mean[b][2]));
        e.c3 = 8'(rnd(mean[b][3]));
        e.last = (b + 1 == tgt);
        pending.insert(pending.size(), e);
      end
      pix.delete();
      grp.delete();
    endfunction

    function void check_entry(entry_t got);
      entry_t x;
      if (pending.size() == 0) begin
        $display("%0t unexpected word idx=%0d", $time, got.idx);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (x != got) begin
        $display("%0t exp idx=%0d %h %h %h %h last=%b got idx=%0d %h %h %h %h last=%b",
                 $time, x.idx, x.c0, x.c1, x.c2, x.c3, x.last,
                 got.idx, got.c0, got.c1, got.c2, got.c3, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_last_pixel = 0, out_stall = 0, cfg_valid = 0;
  logic [7:0] in_chan0 = 0, in_chan1 = 0, in_chan2 = 0, in_chan3 = 0;
  logic [PC_W-1:0] cfg_data = 0;
  logic in_stall, out_valid, out_last_entry, cfg_ready;
  logic [5:0] out_entry_index;
  logic [7:0] out_chan0, out_chan1, out_chan2, out_chan3;
  palette_board board = new();
  longint cycles = 0;
  bit sending = 1;

  palette_bucket_split_quantizer DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function int unsigned gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
           ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
  endfunction

  always @(posedge clk) begin
    entry_t g;
    if (rst_n && out_valid && !out_stall) begin
      g.idx = out_entry_index; g.c0 = out_chan0; g.c1 = out_chan1;
      g.c2 = out_chan2; g.c3 = out_chan3; g.last = out_last_entry;
      board.check_entry(g);
    end
  end

  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (n > 0) begin
        n--;
      end else if (out_stall) begin
        out_stall <= 0;
      end else if (sending && $urandom_range(0, 3) == 0) begin
        n = gap();
        out_stall <= 1;
      end
    end
  end

  task automatic send_pixel(logic [7:0] c0, c1, c2, c3, logic last);
    int unsigned g;
    g = sending ? gap() % 4 : 0;
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_chan0 <= c0; in_chan1 <= c1; in_chan2 <= c2; in_chan3 <= c3;
    in_last_pixel <= last;
    do @(posedge clk); while (in_stall);
    board.note_pixel(c0, c1, c2, c3, last);
    if (last) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic set_colours(logic [PC_W-1:0] v);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.colours = v;
  endtask

  task automatic send_image(int unsigned npix, int unsigned mode);
    logic [7:0] b [4];
    for (int i = 0; i < npix; i++) begin
      if (mode == 0) begin
        foreach (b[c]) b[c] = 8'($urandom);
      end else begin
        foreach (b[c]) b[c] = 8'(($urandom_range(0, 1) ? 40 : 200) + $urandom_range(0, 15));
      end
      send_pixel(b[0], b[1], b[2], b[3], i == npix - 1);
    end
  endtask

  initial begin
    logic [PC_W-1:0] counts [6] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd100, 7'd127};
    int unsigned sent;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // reset colour count, directed extremes
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 0);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1);
    send_pixel(8'h80, 8'h80, 8'h80, 8'h80, 1);
    foreach (counts[k]) begin
      set_colours(counts[k]);
      send_image(k == 5 ? 3 : 6, k % 2);
    end
    set_colours(7'd4);
    send_pixel(8'h7F, 8'h7F, 8'h7F, 8'h7F, 0);
    send_pixel(8'h7F, 8'h7F, 8'h7F, 8'h7F, 1);
    sent = 0;
    while (sent < 400) begin
      int unsigned np;
      if ($urandom_range(0, 3) == 0) set_colours(PC_W'($urandom_range(1, 24)));
      np = $urandom_range(1, 16);
      if (sent > 200 && sent < 220) begin
        sending = 0;
        while (board.pending.size() != 0) @(posedge clk);
        sending = 1;
      end
      send_image(np, $urandom_range(0, 1));
      sent += np;
    end
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

@@ palette_bucket_split_quantizer.f @@
hw/rtl/pbsq_pkg.sv
hw/rtl/pbsq_ram.sv
hw/rtl/pbsq_div.sv
hw/rtl/palette_bucket_split_quantizer.sv
sim/palette_bucket_split_quantizer_test.sv
